// ===== sv/ptrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrs_pkg
// Shared types and constants of the periodic task release scheduler.
// ----------------------------------------------------------------------------
package ptrs_pkg;

  // default sizes of the task table and of the tick counters
  localparam int DEF_MAX_TASKS = 8;
  localparam int DEF_TIME_BITS = 16;

  // fixed field widths of the item channels
  localparam int MODE_W   = 2;
  localparam int HANDLE_W = 16;
  localparam int FIELD_W  = 16;
  localparam int SLOT_W   = 3;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 16;

  // command codes
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK     = 2'd0,
    MODE_DISPATCH = 2'd1,
    MODE_ADD      = 2'd2,
    MODE_RESTART  = 2'd3
  } ptrs_mode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_FULL        = 2'd1,
    STATUS_ZERO_PERIOD = 2'd2
  } ptrs_status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_EX,
    S_FIN
  } ptrs_state_t;

  // control from the sequencer to the task table
  typedef struct packed {
    logic rd;
    logic upd;
    logic add;
  } ptrs_tbl_ctl_t;

endpackage

// ===== sv/ptrs_in_if.sv =====
// ----------------------------------------------------------------------------
// ptrs_in_if
// Command channel: valid/ready handshake with the command item payload.
// ----------------------------------------------------------------------------
interface ptrs_in_if import ptrs_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [HANDLE_W-1:0] task_handle;
  logic [FIELD_W-1:0]  initial_delay;
  logic [FIELD_W-1:0]  period;

  modport source (
    output valid, mode, task_handle, initial_delay, period,
    input  ready
  );

  modport sink (
    input  valid, mode, task_handle, initial_delay, period,
    output ready
  );

endinterface

// ===== sv/ptrs_out_if.sv =====
// ----------------------------------------------------------------------------
// ptrs_out_if
// Result channel: valid/ready handshake with the result item payload.
// ----------------------------------------------------------------------------
interface ptrs_out_if import ptrs_pkg::*; ();

  logic                valid;
  logic                ready;
  logic                released;
  logic [HANDLE_W-1:0] released_handle;
  logic [SLOT_W-1:0]   slot;
  logic [STATUS_W-1:0] status;
  logic                overrun;
  logic [FIELD_W-1:0]  pending;
  logic                last;

  modport source (
    output valid, released, released_handle, slot, status, overrun, pending, last,
    input  ready
  );

  modport sink (
    input  valid, released, released_handle, slot, status, overrun, pending, last,
    output ready
  );

endinterface

// ===== sv/ptrs_table.sv =====
// ----------------------------------------------------------------------------
// ptrs_table
// Task table: valid bits in flops, handle/countdown/period in memories with
// registered reads, first-free-slot search and the countdown update unit.
// ----------------------------------------------------------------------------
module ptrs_table import ptrs_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS,
  parameter int TIME_BITS = DEF_TIME_BITS,
  parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ptrs_tbl_ctl_t        ctl,
  input  logic [IDX_W-1:0]     addr,
  input  logic [HANDLE_W-1:0]  add_handle,
  input  logic [TIME_BITS-1:0] add_delay,
  input  logic [TIME_BITS-1:0] add_period,
  output logic [HANDLE_W-1:0]  rd_handle,
  output logic                 rel,
  output logic [IDX_W-1:0]     free_slot,
  output logic                 full
);

  localparam int CD_W = TIME_BITS + 1;

  logic [MAX_TASKS-1:0] valid;
  logic [HANDLE_W-1:0]  handle_mem [MAX_TASKS];
  logic [CD_W-1:0]      cd_mem     [MAX_TASKS];
  logic [TIME_BITS-1:0] period_mem [MAX_TASKS];

  logic                 valid_q;
  logic [CD_W-1:0]      cd_q;
  logic [TIME_BITS-1:0] period_q;
  logic [CD_W-1:0]      cd_dec;
  logic [CD_W-1:0]      cd_new;
  logic [IDX_W-1:0]     cd_waddr;
  logic [CD_W-1:0]      cd_wdata;
  logic                 cd_we;

  // first free slot, lowest index wins
  always_comb begin
    free_slot = '0;
    full      = 1'b1;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = IDX_W'(i);
        full      = 1'b0;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.add) begin
      valid[free_slot] <= 1'b1;
    end
  end

  // countdown step: a zero countdown wraps, reaching zero releases and reloads
  always_comb begin
    cd_dec = cd_q - CD_W'(1);
    rel    = valid_q && (cd_q != '0) && (cd_dec == '0);
    if (cd_q == '0) begin
      cd_new = '1;
    end else if (cd_dec == '0) begin
      cd_new = {1'b0, period_q};
    end else begin
      cd_new = cd_dec;
    end
  end

  // countdown write port shared by add and update
  always_comb begin
    cd_we    = ctl.add || (ctl.upd && valid_q);
    cd_waddr = ctl.add ? free_slot : addr;
    cd_wdata = ctl.add ? ({1'b0, add_delay} + CD_W'(1)) : cd_new;
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (ctl.add) begin
      handle_mem[free_slot] <= add_handle;
      period_mem[free_slot] <= add_period;
    end
    if (cd_we) begin
      cd_mem[cd_waddr] <= cd_wdata;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      valid_q   <= valid[addr];
      rd_handle <= handle_mem[addr];
      cd_q      <= cd_mem[addr];
      period_q  <= period_mem[addr];
    end
  end

endmodule

// ===== sv/periodic_task_release_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler
// Time-triggered cooperative scheduler: pending tick counter with overrun
// flag and a periodic task table walked slot by slot per dispatch of a pending tick.
// ----------------------------------------------------------------------------
// Tick, add, restart and a dispatch with nothing pending: result registered
// from the execute state once rsp can take it; the next item waits for idle.
// Dispatch with a tick pending: slots walked in turn, each a read state then
// an update state, set by the single registered read port; the last result
// comes from the finish state, and a result waiting on rsp stalls the walk.
// Reset clears valid bits, pending count and overrun flag, sets tick_limit to 1.
module periodic_task_release_scheduler import ptrs_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  ptrs_in_if.sink            cmd,
  ptrs_out_if.source         rsp
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CMP_W = TIME_BITS + LIMIT_W;

  ptrs_state_t          state, state_next;
  ptrs_mode_t           cur_mode;
  logic [HANDLE_W-1:0]  cur_handle;
  logic [FIELD_W-1:0]   cur_delay;
  logic [FIELD_W-1:0]   cur_period;
  logic [LIMIT_W-1:0]   tick_limit;

  logic [TIME_BITS-1:0] pending, pending_next;
  logic                 overrun, overrun_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic                 have_held, have_held_next;
  logic [HANDLE_W-1:0]  held_handle, held_handle_next;
  logic [IDX_W-1:0]     held_slot, held_slot_next;

  // table interface
  ptrs_tbl_ctl_t        ctl;
  logic [HANDLE_W-1:0]  rd_handle;
  logic                 rel;
  logic [IDX_W-1:0]     free_slot;
  logic                 full;

  // result staging
  logic                 emit;
  logic                 e_rel;
  logic [HANDLE_W-1:0]  e_handle;
  logic [IDX_W-1:0]     e_slot;
  ptrs_status_t         e_status;
  logic                 e_last;
  logic                 rsp_valid;

  logic                 can_emit;
  logic                 ex_stall;
  logic                 last_slot;
  logic [TIME_BITS-1:0] pending_inc;
  logic [CMP_W-1:0]     inc_ext;
  logic [CMP_W-1:0]     lim_ext;
  logic [TIME_BITS+FIELD_W-1:0] delay_ext;
  logic [TIME_BITS+FIELD_W-1:0] period_ext;
  logic [TIME_BITS-1:0] delay_t;
  logic [TIME_BITS-1:0] period_t;
  logic [TIME_BITS+FIELD_W-1:0] pend_ext;
  logic [IDX_W+SLOT_W-1:0]      slot_ext;

  ptrs_table #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .addr       (idx),
    .add_handle (cur_handle),
    .add_delay  (delay_t),
    .add_period (period_t),
    .rd_handle  (rd_handle),
    .rel        (rel),
    .free_slot  (free_slot),
    .full       (full)
  );

  // field narrowing and counter helpers
  always_comb begin
    delay_ext   = {{TIME_BITS{1'b0}}, cur_delay};
    period_ext  = {{TIME_BITS{1'b0}}, cur_period};
    delay_t     = delay_ext[TIME_BITS-1:0];
    period_t    = period_ext[TIME_BITS-1:0];
    pending_inc = (pending == '1) ? pending : pending + TIME_BITS'(1);
    inc_ext     = {{LIMIT_W{1'b0}}, pending_inc};
    lim_ext     = {{TIME_BITS{1'b0}}, tick_limit};
    last_slot   = (idx == IDX_W'(MAX_TASKS - 1));
  end

  assign can_emit  = !rsp_valid || rsp.ready;
  assign ex_stall  = rel && have_held && !can_emit;
  assign cmd.ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (can_emit) begin
          if (cur_mode == MODE_DISPATCH && pending != '0) state_next = S_RD;
          else state_next = S_IDLE;
        end
      end
      S_RD: state_next = S_EX;
      S_EX: begin
        if (!ex_stall) state_next = last_slot ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (can_emit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl              = '0;
    emit             = 1'b0;
    e_rel            = 1'b0;
    e_handle         = '0;
    e_slot           = '0;
    e_status         = STATUS_OK;
    e_last           = 1'b1;
    pending_next     = pending;
    overrun_next     = overrun;
    idx_next         = idx;
    have_held_next   = have_held;
    held_handle_next = held_handle;
    held_slot_next   = held_slot;
    unique case (state)
      S_IDLE: begin
      end
      S_EXEC: begin
        if (can_emit) begin
          unique case (cur_mode)
            MODE_TICK: begin
              pending_next = pending_inc;
              overrun_next = overrun || (inc_ext > lim_ext);
              emit         = 1'b1;
            end
            MODE_DISPATCH: begin
              if (pending == '0) begin
                emit = 1'b1;
              end else begin
                pending_next   = pending - TIME_BITS'(1);
                idx_next       = '0;
                have_held_next = 1'b0;
              end
            end
            MODE_ADD: begin
              emit = 1'b1;
              if (full) begin
                e_status = STATUS_FULL;
              end else if (period_t == '0) begin
                e_status = STATUS_ZERO_PERIOD;
              end else begin
                ctl.add = 1'b1;
                e_slot  = free_slot;
              end
            end
            MODE_RESTART: begin
              pending_next = '0;
              overrun_next = 1'b0;
              emit         = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        ctl.rd = 1'b1;
      end
      S_EX: begin
        if (!ex_stall) begin
          ctl.upd = 1'b1;
          // a new release flushes the previous one, which is then not last
          if (rel) begin
            if (have_held) begin
              emit     = 1'b1;
              e_rel    = 1'b1;
              e_handle = held_handle;
              e_slot   = held_slot;
              e_last   = 1'b0;
            end
            have_held_next   = 1'b1;
            held_handle_next = rd_handle;
            held_slot_next   = idx;
          end
          if (!last_slot) idx_next = idx + IDX_W'(1);
        end
      end
      S_FIN: begin
        if (can_emit) begin
          emit = 1'b1;
          if (have_held) begin
            e_rel    = 1'b1;
            e_handle = held_handle;
            e_slot   = held_slot;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result payload narrowing
  always_comb begin
    pend_ext = {{FIELD_W{1'b0}}, pending_next};
    slot_ext = {{SLOT_W{1'b0}}, e_slot};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pending    <= '0;
      overrun    <= 1'b0;
      tick_limit <= LIMIT_W'(1);
      have_held  <= 1'b0;
      idx        <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      pending   <= pending_next;
      overrun   <= overrun_next;
      have_held <= have_held_next;
      idx       <= idx_next;
      if (cfg_we) tick_limit <= cfg_wdata;
      if (emit) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
    end
  end

  // command item capture and held release
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cur_mode   <= ptrs_mode_t'(cmd.mode);
      cur_handle <= cmd.task_handle;
      cur_delay  <= cmd.initial_delay;
      cur_period <= cmd.period;
    end
    held_handle <= held_handle_next;
    held_slot   <= held_slot_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.released        <= e_rel;
      rsp.released_handle <= e_handle;
      rsp.slot            <= slot_ext[SLOT_W-1:0];
      rsp.status          <= e_status;
      rsp.overrun         <= overrun_next;
      rsp.pending         <= pend_ext[FIELD_W-1:0];
      rsp.last            <= e_last;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for periodic_task_release_scheduler. A shadow of the
// task table, pending tick count and overrun flag predicts every result item;
// directed checks cover add rules, dispatch corner cases and the tick limit
// extremes, then tick/dispatch traffic with random stalls.
// ----------------------------------------------------------------------------
module tb;
  import ptrs_pkg::*;

  localparam int NUM_SLOTS     = DEF_MAX_TASKS;
  localparam int SETTLE_CYCLES = 2 * DEF_MAX_TASKS + 12;
  localparam int CYCLE_LIMIT   = 3_000_000;

  typedef struct packed {
    logic                released;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
    ptrs_status_t        status;
    logic                overrun;
    logic [FIELD_W-1:0]  pending;
    logic                last;
  } sched_result_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  ptrs_in_if  cmd_if ();
  ptrs_out_if rsp_if ();

  periodic_task_release_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_if),
    .rsp       (rsp_if)
  );

  // results still owed by the block, oldest first
  sched_result_t due_results[$];
  sched_result_t want;
  int            err_count    = 0;
  int            result_count = 0;
  int unsigned   cycle_count  = 0;
  bit            idle_on      = 1'b1;
  int            stall_left   = 0;

  // shadow copy of the scheduler state
  bit                       slot_busy   [NUM_SLOTS];
  logic [HANDLE_W-1:0]      slot_handle [NUM_SLOTS];
  logic [DEF_TIME_BITS:0]   slot_count  [NUM_SLOTS];
  logic [DEF_TIME_BITS-1:0] slot_period [NUM_SLOTS];
  logic [DEF_TIME_BITS-1:0] ticks_owed;
  logic                     overrun_seen;
  logic [LIMIT_W-1:0]       limit_shadow;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [FIELD_W-1:0] rnd16();
    return FIELD_W'($urandom);
  endfunction

  // apply one command item to the shadow and queue the results it causes
  function automatic void advance_schedule(input ptrs_mode_t m,
                                           input logic [HANDLE_W-1:0] h,
                                           input logic [FIELD_W-1:0] d,
                                           input logic [FIELD_W-1:0] p);
    sched_result_t r;
    int            fired[$];
    int            free_idx;
    r        = '0;
    r.status = STATUS_OK;
    r.last   = 1'b1;
    free_idx = -1;
    case (m)
      MODE_TICK: begin
        if (ticks_owed != '1) ticks_owed = ticks_owed + 1'b1;
        if (ticks_owed > limit_shadow) overrun_seen = 1'b1;
      end
      MODE_DISPATCH: begin
        if (ticks_owed != '0) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_busy[i]) begin
              // a countdown already at zero wraps to all ones and stays quiet
              slot_count[i] = slot_count[i] - 1'b1;
              if (slot_count[i] == '0) begin
                fired.push_back(i);
                slot_count[i] = {1'b0, slot_period[i]};
              end
            end
          end
          ticks_owed = ticks_owed - 1'b1;
        end
      end
      MODE_ADD: begin
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (!slot_busy[i]) free_idx = i;
        end
        // full table is checked before the period
        if (free_idx < 0) begin
          r.status = STATUS_FULL;
        end else if (p == '0) begin
          r.status = STATUS_ZERO_PERIOD;
        end else begin
          slot_busy[free_idx]   = 1'b1;
          slot_handle[free_idx] = h;
          slot_count[free_idx]  = {1'b0, d} + 1'b1;
          slot_period[free_idx] = p;
          r.slot                = SLOT_W'(free_idx);
        end
      end
      default: begin
        ticks_owed   = '0;
        overrun_seen = 1'b0;
      end
    endcase
    r.overrun = overrun_seen;
    r.pending = ticks_owed;
    if (fired.size() == 0) begin
      due_results.push_back(r);
    end else begin
      foreach (fired[k]) begin
        r.released = 1'b1;
        r.handle   = slot_handle[fired[k]];
        r.slot     = SLOT_W'(fired[k]);
        r.last     = (k == fired.size() - 1);
        due_results.push_back(r);
      end
    end
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got_v,
                             input logic [31:0] want_v);
    if (got_v !== want_v)
      report_error($sformatf("result %0d field %s got 0x%0h expected 0x%0h",
                             result_count, name, got_v, want_v));
  endtask

  // drive one command item and wait until it is taken
  task automatic send_cmd(input ptrs_mode_t m, input logic [HANDLE_W-1:0] h,
                          input logic [FIELD_W-1:0] d, input logic [FIELD_W-1:0] p);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.mode          <= m;
    cmd_if.task_handle   <= h;
    cmd_if.initial_delay <= d;
    cmd_if.period        <= p;
    @(posedge clk);
    while (!(cmd_if.valid && cmd_if.ready)) @(posedge clk);
    advance_schedule(m, h, d, p);
  endtask

  // stop sending and wait until every owed result has come back
  task automatic quiesce();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_limit(input logic [LIMIT_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we       <= 1'b0;
    limit_shadow = v;
  endtask

  // single random item of any kind, adds carry random content
  task automatic send_noise_cmd(input int tick_pct);
    int                 pick;
    ptrs_mode_t         m;
    logic [FIELD_W-1:0] p;
    pick = $urandom_range(0, 99);
    if (pick < 6) m = MODE_RESTART;
    else if (pick < 16) m = MODE_ADD;
    else if (pick < 16 + tick_pct) m = MODE_TICK;
    else m = MODE_DISPATCH;
    p = ($urandom_range(0, 3) == 0) ? '0 : rnd16();
    send_cmd(m, rnd16(), rnd16(), p);
  endtask

  // empty table: zero period rejected, fill all slots, then full rejects
  task automatic test_add_rules();
    send_cmd(MODE_ADD, 16'h1234, 16'd5, 16'd0);
    send_cmd(MODE_ADD, 16'hFFFF, 16'd0, 16'd3);
    send_cmd(MODE_ADD, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_cmd(MODE_ADD, 16'hA5A5, 16'd2, 16'd3);
    send_cmd(MODE_ADD, 16'h5A5A, 16'd3, 16'd5);
    send_cmd(MODE_ADD, 16'h0F0F, 16'd0, 16'd6);
    send_cmd(MODE_ADD, 16'hF0F0, 16'd4, 16'd4);
    send_cmd(MODE_ADD, 16'h8001, 16'd6, 16'd8);
    send_cmd(MODE_ADD, 16'h7FFE, 16'd0, 16'd2);
    // full table wins over a zero period
    send_cmd(MODE_ADD, 16'h4321, 16'd1, 16'd0);
    send_cmd(MODE_ADD, 16'h4321, 16'd1, 16'd1);
  endtask

  // dispatch with nothing pending, releasing several, releasing none
  task automatic test_dispatch_cases();
    send_cmd(MODE_DISPATCH, rnd16(), rnd16(), rnd16());
    send_cmd(MODE_TICK, rnd16(), rnd16(), rnd16());
    send_cmd(MODE_TICK, rnd16(), rnd16(), rnd16());
    send_cmd(MODE_DISPATCH, rnd16(), rnd16(), rnd16());
    send_cmd(MODE_DISPATCH, rnd16(), rnd16(), rnd16());
    send_cmd(MODE_DISPATCH, rnd16(), rnd16(), rnd16());
    send_cmd(MODE_RESTART, rnd16(), rnd16(), rnd16());
    repeat (3) send_cmd(MODE_TICK, rnd16(), rnd16(), rnd16());
    repeat (3) send_cmd(MODE_DISPATCH, rnd16(), rnd16(), rnd16());
  endtask

  // limit at its top value never flags overrun; a zero limit flags on one tick
  task automatic test_tick_limit_extremes();
    quiesce();
    write_tick_limit('1);
    repeat (4) send_cmd(MODE_TICK, rnd16(), rnd16(), rnd16());
    send_cmd(MODE_DISPATCH, rnd16(), rnd16(), rnd16());
    send_cmd(MODE_RESTART, rnd16(), rnd16(), rnd16());
    quiesce();
    write_tick_limit('0);
    send_cmd(MODE_TICK, rnd16(), rnd16(), rnd16());
    send_cmd(MODE_DISPATCH, rnd16(), rnd16(), rnd16());
    send_cmd(MODE_RESTART, rnd16(), rnd16(), rnd16());
  endtask

  // mostly tick bursts followed by as many dispatches, plus random items
  task automatic run_traffic_phase(input logic [LIMIT_W-1:0] lim, input int tick_pct,
                                   input int n_items);
    int sent;
    int k;
    quiesce();
    write_tick_limit(lim);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(1, 4);
        repeat (k) send_cmd(MODE_TICK, rnd16(), rnd16(), rnd16());
        repeat (k) send_cmd(MODE_DISPATCH, rnd16(), rnd16(), rnd16());
        sent += 2 * k;
      end else begin
        send_noise_cmd(tick_pct);
        sent++;
      end
    end
  endtask

  task automatic test_tick_limit_phases();
    run_traffic_phase('0, 50, 100);
    run_traffic_phase(LIMIT_W'($urandom_range(2, 40)), 40, 100);
    run_traffic_phase(rnd16(), 45, 90);
    // last stretch runs without stalls on either side
    idle_on = 1'b0;
    run_traffic_phase(LIMIT_W'(1), 40, 90);
  endtask

  // result side: random stall bursts while idling is enabled
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // compare each result item with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (due_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        want = due_results.pop_front();
        check_field("released", rsp_if.released, want.released);
        check_field("released_handle", rsp_if.released_handle, want.handle);
        check_field("slot", rsp_if.slot, want.slot);
        check_field("status", rsp_if.status, want.status);
        check_field("overrun", rsp_if.overrun, want.overrun);
        check_field("pending", rsp_if.pending, want.pending);
        check_field("last", rsp_if.last, want.last);
      end
      result_count++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_count,
               due_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    cmd_if.valid         <= 1'b0;
    cmd_if.mode          <= MODE_TICK;
    cmd_if.task_handle   <= '0;
    cmd_if.initial_delay <= '0;
    cmd_if.period        <= '0;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    ticks_owed   = '0;
    overrun_seen = 1'b0;
    limit_shadow = LIMIT_W'(1);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_add_rules();
    test_dispatch_cases();
    test_tick_limit_extremes();
    test_tick_limit_phases();
    quiesce();

    if (err_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
